// File: rtl/core/btlpm_pkg.sv
// Shared types and constants of the binary trie longest-prefix-match table.
package btlpm_pkg;

	// Width of the prefix_length field on the input stream.
	localparam int LEN_W = 4;

	// Command codes carried in the input tuser.
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// States of the back-end sequencer.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_LAST,
		ST_DONE
	} back_state_t;

endpackage

// File: rtl/core/btlpm_front.sv
// Front end: decode an input beat and compute the trie slot of an insert.
module btlpm_front import btlpm_pkg::*; #(
	parameter int ADDRESS_BITS = 8,
	parameter int HOP_BITS     = 16,
	parameter int NODE_W       = ADDRESS_BITS + 1,
	parameter int ITEM_W       = 1 + NODE_W + ADDRESS_BITS + HOP_BITS
) (
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    command,
	input  logic [ADDRESS_BITS-1:0] address,
	input  logic [LEN_W-1:0]        prefix_length,
	input  logic [HOP_BITS-1:0]     next_hop,
	input  logic                    clear_busy,
	output logic                    push,
	output logic [ITEM_W-1:0]       item,
	input  logic                    q_ready
);

	localparam int LVL_W = $clog2(ADDRESS_BITS + 1);

	logic [LVL_W-1:0]  len_sat;
	logic [LVL_W-1:0]  shift;
	logic [NODE_W-1:0] base;
	logic [NODE_W-1:0] offs;
	logic [NODE_W-1:0] node;

	// Saturate over-long prefixes to a full-length host route.
	always_comb begin
		if (32'(prefix_length) > ADDRESS_BITS) begin
			len_sat = LVL_W'(ADDRESS_BITS);
		end else begin
			len_sat = LVL_W'(prefix_length);
		end
		shift = LVL_W'(ADDRESS_BITS) - len_sat;
		base  = (NODE_W'(1) << len_sat) - NODE_W'(1);
		offs  = NODE_W'(address) >> shift;
		node  = base + offs;
	end

	// Hold off new beats while the node store is being cleared.
	assign in_ready = q_ready && !clear_busy;
	assign push     = in_valid && in_ready;
	assign item     = {(command == CMD_LOOKUP), node, address, next_hop};

endmodule

// File: rtl/core/btlpm_queue.sv
// Two-entry queue between the front end and the back end.
module btlpm_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         push_ready,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         pop_valid
);

	logic [W-1:0] slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/core/btlpm_back.sv
// Back end: node store with clear sweep, insert writes, level-by-level lookup walk, result register.
module btlpm_back import btlpm_pkg::*; #(
	parameter int ADDRESS_BITS = 8,
	parameter int HOP_BITS     = 16,
	parameter int NODE_W       = ADDRESS_BITS + 1,
	parameter int ITEM_W       = 1 + NODE_W + ADDRESS_BITS + HOP_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [ITEM_W-1:0]   item,
	input  logic                item_valid,
	output logic                pop,
	output logic                clear_busy,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [HOP_BITS-1:0] hop_found,
	output logic                drop
);

	localparam int LVL_W      = $clog2(ADDRESS_BITS + 1);
	localparam int NODE_COUNT = (2 << ADDRESS_BITS) - 1;

	// Node store: valid bit on top of the next hop.
	logic [HOP_BITS:0] mem [NODE_COUNT];

	back_state_t state_q, state_d;

	logic                    it_lookup;
	logic [NODE_W-1:0]       it_node;
	logic [ADDRESS_BITS-1:0] it_addr;
	logic [HOP_BITS-1:0]     it_hop;

	logic [NODE_W-1:0]       clr_q;
	logic [LVL_W-1:0]        level_q;
	logic [NODE_W-1:0]       idx_q;
	logic [ADDRESS_BITS-1:0] addr_q;
	logic                    found_q;
	logic [HOP_BITS-1:0]     hop_q;
	logic                    rd_pend_q;
	logic [HOP_BITS:0]       rd_q;
	logic                    out_valid_q;
	logic [HOP_BITS-1:0]     out_hop_q;
	logic                    out_drop_q;

	logic                    wr_en;
	logic [NODE_W-1:0]       wr_addr;
	logic [HOP_BITS:0]       wr_data;
	logic                    rd_en;
	logic                    start_walk;
	logic                    out_load;

	assign {it_lookup, it_node, it_addr, it_hop} = item;

	always_comb begin
		state_d    = state_q;
		wr_en      = 1'b0;
		wr_addr    = it_node;
		wr_data    = {1'b1, it_hop};
		rd_en      = 1'b0;
		pop        = 1'b0;
		start_walk = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				if (clr_q == NODE_W'(NODE_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					pop = 1'b1;
					if (it_lookup) begin
						start_walk = 1'b1;
						state_d    = ST_WALK;
					end else begin
						wr_en = 1'b1;
					end
				end
			end
			ST_WALK: begin
				rd_en = 1'b1;
				if (level_q == LVL_W'(ADDRESS_BITS)) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
			level_q     <= '0;
			found_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= rd_en;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + NODE_W'(1);
			end
			if (start_walk) begin
				level_q <= '0;
				found_q <= 1'b0;
			end else begin
				if (rd_en) begin
					level_q <= level_q + LVL_W'(1);
				end
				// Deeper levels arrive later, so the last valid hit wins.
				if (rd_pend_q && rd_q[HOP_BITS]) begin
					found_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_walk) begin
			idx_q  <= '0;
			addr_q <= it_addr;
		end else if (rd_en) begin
			// Descend: child = 2*idx + 1 + next address bit.
			idx_q  <= (idx_q << 1) + NODE_W'(1) + NODE_W'(addr_q[ADDRESS_BITS-1]);
			addr_q <= addr_q << 1;
		end
		if (rd_pend_q && rd_q[HOP_BITS]) begin
			hop_q <= rd_q[HOP_BITS-1:0];
		end
		if (out_load) begin
			out_hop_q  <= found_q ? hop_q : '0;
			out_drop_q <= !found_q;
		end
	end

	assign clear_busy = (state_q == ST_CLEAR);
	assign out_valid  = out_valid_q;
	assign hop_found  = out_hop_q;
	assign drop       = out_drop_q;

endmodule

// File: rtl/core/binary_trie_longest_prefix_match.sv
// Top level of the binary trie longest-prefix-match forwarding table.
//
// Channel  Dir  Beat contents (lowest bit up)
// s_*      in   tuser: command; tdata: address, prefix_length, next_hop, zero pad
// m_*      out  tuser: drop; tdata: hop_found, zero pad
//
// An insert is one node-store write. A lookup makes one node-store read per
// trie level, from the root down to the full-length prefix, through the
// single read port.
// After reset the node store is swept clear, all 2^(ADDRESS_BITS+1) - 1 nodes
// (511 by default); s_tready stays low during that sweep.
// A two-entry queue lets input beats land while a lookup walks, and the
// result register frees the walk from a stalled m_tready until a new result
// meets a still-full register; the back end then waits in ST_DONE.
module binary_trie_longest_prefix_match import btlpm_pkg::*; #(
	parameter int ADDRESS_BITS = 8,
	parameter int HOP_BITS     = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        s_tvalid,
	output logic                                        s_tready,
	// address, prefix_length, next_hop, zero pad
	input  logic [((ADDRESS_BITS+LEN_W+HOP_BITS+7)/8)*8-1:0] s_tdata,
	// command
	input  logic                                        s_tuser,
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	// hop_found, zero pad
	output logic [((HOP_BITS+7)/8)*8-1:0]               m_tdata,
	// drop
	output logic                                        m_tuser
);

	localparam int NODE_W = ADDRESS_BITS + 1;
	localparam int ITEM_W = 1 + NODE_W + ADDRESS_BITS + HOP_BITS;
	localparam int OUT_W  = ((HOP_BITS + 7) / 8) * 8;

	logic              push;
	logic [ITEM_W-1:0] push_item;
	logic              q_ready;
	logic              pop;
	logic [ITEM_W-1:0] pop_item;
	logic              pop_valid;
	logic              clear_busy;
	logic [HOP_BITS-1:0] hop_found;

	// Classify the beat and find its trie slot.
	btlpm_front #(
		.ADDRESS_BITS(ADDRESS_BITS),
		.HOP_BITS    (HOP_BITS),
		.NODE_W      (NODE_W),
		.ITEM_W      (ITEM_W)
	) u_front (
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.command      (s_tuser),
		.address      (s_tdata[ADDRESS_BITS-1:0]),
		.prefix_length(s_tdata[ADDRESS_BITS+LEN_W-1:ADDRESS_BITS]),
		.next_hop     (s_tdata[ADDRESS_BITS+LEN_W+HOP_BITS-1:ADDRESS_BITS+LEN_W]),
		.clear_busy   (clear_busy),
		.push         (push),
		.item         (push_item),
		.q_ready      (q_ready)
	);

	// Decouple the accepting side from the trie walk.
	btlpm_queue #(
		.W(ITEM_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_item),
		.push_ready(q_ready),
		.pop       (pop),
		.pop_data  (pop_item),
		.pop_valid (pop_valid)
	);

	// Execute inserts and lookups against the node store.
	btlpm_back #(
		.ADDRESS_BITS(ADDRESS_BITS),
		.HOP_BITS    (HOP_BITS),
		.NODE_W      (NODE_W),
		.ITEM_W      (ITEM_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (pop_item),
		.item_valid(pop_valid),
		.pop       (pop),
		.clear_busy(clear_busy),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.hop_found (hop_found),
		.drop      (m_tuser)
	);

	assign m_tdata = OUT_W'(hop_found);

endmodule
